// File: hdl/vei_pkg.sv
package vei_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_PARAMS = 16;
  localparam int DEF_MAX_COLS   = 128;
  localparam int DEF_MAX_ROWS   = 64;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 8;
  localparam int QDEPTH  = 2;

  // Register reset values
  localparam logic [6:0] RST_ROWS = 7'd24;
  localparam logic [7:0] RST_COLS = 8'd80;
  localparam logic [2:0] RST_FG   = 3'd7;
  localparam logic [2:0] RST_BG   = 3'd0;

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_FG   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_BG   = 2'd3;

  // C0 and C1 controls
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_SUB   = 8'h1a;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_CSI   = 8'h9b;

  // Sequence bytes
  localparam logic [7:0] CH_LBRK  = 8'h5b;  // [
  localparam logic [7:0] CH_RBRK  = 8'h5d;  // ]
  localparam logic [7:0] CH_PCT   = 8'h25;  // %
  localparam logic [7:0] CH_NEL   = 8'h45;  // E
  localparam logic [7:0] CH_IND   = 8'h44;  // D
  localparam logic [7:0] CH_SAVE  = 8'h37;  // 7
  localparam logic [7:0] CH_REST  = 8'h38;  // 8
  localparam logic [7:0] CH_RIS   = 8'h63;  // c
  localparam logic [7:0] CH_SS2   = 8'h4e;  // N
  localparam logic [7:0] CH_SS3   = 8'h4f;  // O
  localparam logic [7:0] CH_QMARK = 8'h3f;  // ?
  localparam logic [7:0] CH_SEMI  = 8'h3b;  // ;
  localparam logic [7:0] CH_D0    = 8'h30;  // 0
  localparam logic [7:0] CH_D9    = 8'h39;  // 9
  localparam logic [7:0] CH_CUU   = 8'h41;  // A
  localparam logic [7:0] CH_CUD   = 8'h42;  // B
  localparam logic [7:0] CH_CUF   = 8'h43;  // C
  localparam logic [7:0] CH_CUB   = 8'h44;  // D
  localparam logic [7:0] CH_CUP   = 8'h48;  // H
  localparam logic [7:0] CH_SGR   = 8'h6d;  // m
  localparam logic [7:0] CH_SM    = 8'h68;  // h
  localparam logic [7:0] CH_RM    = 8'h6c;  // l
  localparam logic [7:0] CH_STBM  = 8'h72;  // r

  // SGR and mode numbers
  localparam logic [7:0] SGR_NORM   = 8'd0;
  localparam logic [7:0] SGR_BOLD   = 8'd1;
  localparam logic [7:0] SGR_FAINT  = 8'd2;
  localparam logic [7:0] SGR_UL     = 8'd4;
  localparam logic [7:0] SGR_REV    = 8'd7;
  localparam logic [7:0] SGR_NOBOLD = 8'd22;
  localparam logic [7:0] SGR_NOUL   = 8'd24;
  localparam logic [7:0] SGR_NOREV  = 8'd27;
  localparam logic [7:0] SGR_FG_UL  = 8'd38;
  localparam logic [7:0] SGR_FG_DEF = 8'd39;
  localparam logic [7:0] SGR_FG0    = 8'd30;
  localparam logic [7:0] SGR_FG7    = 8'd37;
  localparam logic [7:0] SGR_BG0    = 8'd40;
  localparam logic [7:0] SGR_BG7    = 8'd47;
  localparam logic [7:0] MODE_LNM   = 8'd20;
  localparam logic [7:0] DEC_OM     = 8'd6;
  localparam logic [7:0] DEC_AWM    = 8'd7;

  typedef enum logic [3:0] {
    CL_PRINT, CL_LOWCTL, CL_NUL, CL_DEL, CL_BEL, CL_BS, CL_LF, CL_CR,
    CL_ABORT, CL_ESC, CL_CSI
  } cls_e;

  typedef enum logic [2:0] {
    PS_NORMAL, PS_ESC, PS_SQUARE, PS_GETPARS, PS_INPARS, PS_PARK
  } pstate_e;

  typedef enum logic [1:0] {
    ACT_NONE, ACT_WRITE, ACT_CLEAR, ACT_BELL
  } act_e;

  typedef enum logic {EX_RUN, EX_WALK} ex_e;

  typedef struct packed {
    logic       rev;
    logic       ul;
    logic       bold;
    logic [2:0] bg;
    logic [2:0] fg;
  } attr_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       eow;
    cls_e       cls;
  } item_t;

  typedef struct packed {
    act_e             action;
    logic [7:0]       glyph;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    attr_t            attr;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             show;
  } res_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pos_t;

endpackage

// File: hdl/vei_in_if.sv
interface vei_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_write;

  modport source (output valid, byte_in, end_of_write, input ready);
  modport sink   (input valid, byte_in, end_of_write, output ready);
endinterface

// File: hdl/vei_out_if.sv
interface vei_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action_code;
  logic [7:0] glyph;
  logic [6:0] cell_col;
  logic [5:0] cell_row;
  logic [2:0] cell_fg;
  logic [2:0] cell_bg;
  logic       cell_bold;
  logic       cell_underline;
  logic       cell_reverse;
  logic [6:0] cursor_col_out;
  logic [5:0] cursor_row_out;
  logic       show_cursor;

  modport source (output valid, action_code, glyph, cell_col, cell_row, cell_fg, cell_bg,
                  cell_bold, cell_underline, cell_reverse, cursor_col_out,
                  cursor_row_out, show_cursor, input ready);
  modport sink   (input valid, action_code, glyph, cell_col, cell_row, cell_fg, cell_bg,
                  cell_bold, cell_underline, cell_reverse, cursor_col_out,
                  cursor_row_out, show_cursor, output ready);
endinterface

// File: hdl/vt100_escape_interpreter.sv
// VT100 byte interpreter.
// in_i carries one terminal byte per transfer plus an end-of-write flag;
// out_o returns exactly one result per byte: action (none, write cell,
// clear screen, bell), the written cell with its attributes, and the
// cursor after the byte. show_cursor echoes the end-of-write flag.
// cfg_we_i/cfg_idx_i/cfg_data_i write rows, columns and default colours;
// write them only while no byte is in flight.
// A byte is stored in the queue; the executor then registers its result.
// Throughput: one byte per cycle while out_o takes results, except the
// final byte of an SGR or set/reset-mode sequence with n parameters, as
// the executor walks the stored parameter list one entry a cycle, the last
// entry waiting for out_o. A two-entry queue sits between the classifier
// and the executor; the result register reloads in the cycle it is taken.
// Reset: cursor home, default attributes, full-screen margins, autowrap
// and newline modes on, parser in ground state; no clearing pass.
// When out_o stalls the result holds, the executor stops and the queue
// fills; in_i.ready drops once both queue entries are taken.
module vt100_escape_interpreter import vei_pkg::*; #(
  parameter int MAX_PARAMS = DEF_MAX_PARAMS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vei_in_if.sink            in_i,
  vei_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // front: byte classification and short queue
  vei_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // back: parser, cursor/attribute state, result register
  vei_back #(
    .MAX_PARAMS (MAX_PARAMS),
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_o      (out_o)
  );

`ifndef SYNTHESIS
  // cell fields are blank unless a cell is written
  a_blank_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.action_code != ACT_WRITE |->
      out_o.glyph == 8'd0 && out_o.cell_col == 7'd0 && out_o.cell_row == 6'd0)
    else $error("cell fields set without a cell write");

  // a cell write never moves the cursor off the written row
  a_write_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.action_code == ACT_WRITE |->
      out_o.cursor_row_out == out_o.cell_row)
    else $error("cursor row differs from written cell row");

  // back-pressure on the input only with a full queue
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> q_valid)
    else $error("input stalled with an empty queue");
`endif

endmodule

// File: hdl/vei_front.sv
module vei_front import vei_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  vei_in_if.sink in_i,
  output logic  q_valid_o,
  output item_t q_item_o,
  input  logic  q_pop_i
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  item_t          ent_q [QDEPTH];
  logic [PW-1:0]  wp_q, rp_q;
  logic [CW-1:0]  cnt_q;
  logic           push, pop;

  function automatic cls_e classify(input logic [7:0] b);
    cls_e r;
    case (b)
      CH_NUL, CH_TAB: r = CL_NUL;
      CH_BEL:         r = CL_BEL;
      CH_BS:          r = CL_BS;
      CH_LF:          r = CL_LF;
      CH_CR:          r = CL_CR;
      CH_CAN, CH_SUB: r = CL_ABORT;
      CH_ESC:         r = CL_ESC;
      CH_CSI:         r = CL_CSI;
      CH_DEL:         r = CL_DEL;
      default:        r = (b < CH_SPACE) ? CL_LOWCTL : CL_PRINT;
    endcase
    return r;
  endfunction

  assign in_i.ready = (cnt_q != CW'(QDEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_pop_i && (cnt_q != '0);
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= '{byte_in: in_i.byte_in, eow: in_i.end_of_write,
                       cls: classify(in_i.byte_in)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= PW'(wp_q + 1'b1);
      if (pop)  rp_q <= PW'(rp_q + 1'b1);
      cnt_q <= CW'(cnt_q + CW'(push) - CW'(pop));
    end
  end

endmodule

// File: hdl/vei_back.sv
module vei_back import vei_pkg::*; #(
  parameter int MAX_PARAMS = DEF_MAX_PARAMS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              q_pop_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  vei_out_if.source         out_o
);

  localparam int CNT_W = $clog2(MAX_PARAMS + 1);
  localparam int IDX_W = $clog2(MAX_PARAMS);
  localparam int RST_R = (int'(RST_ROWS) > MAX_ROWS) ? MAX_ROWS : int'(RST_ROWS);
  localparam logic [ROW_W-1:0] RST_BOT = ROW_W'(RST_R - 1);

  // configuration
  logic [6:0] rows_q;
  logic [7:0] cols_q;
  logic [2:0] dfg_q, dbg_q;

  // parser and terminal state
  pstate_e          ps_q, ps_d;
  logic             priv_q, priv_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       acc_q, acc_d;
  logic [7:0]       par_q [MAX_PARAMS];
  logic [7:0]       par_d [MAX_PARAMS];
  logic [COL_W-1:0] col_q, col_d, scol_q, scol_d;
  logic [ROW_W-1:0] row_q, row_d, srow_q, srow_d;
  logic             wrap_q, wrap_d;
  attr_t            attr_q, attr_d, sattr_q, sattr_d;
  logic [ROW_W-1:0] top_q, top_d, bot_q, bot_d;
  logic             org_q, org_d, awm_q, awm_d, lnm_q, lnm_d;

  // parameter walk
  ex_e              ex_q, ex_d;
  logic             wsgr_q, wsgr_d, won_q, won_d, weow_q, weow_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             start_walk, walk_done, take;

  // result register
  logic             ov_q, ov_d;
  res_t             res_q, res_d;

  logic [6:0]       rows_e;
  logic [7:0]       cols_e;
  logic             out_free;
  attr_t            dattr;

  assign rows_e   = (rows_q < 7'd2) ? 7'd2 :
                    (rows_q > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_q;
  assign cols_e   = (cols_q < 8'd2) ? 8'd2 :
                    (cols_q > 8'(MAX_COLS)) ? 8'(MAX_COLS) : cols_q;
  assign out_free = !ov_q || out_o.ready;
  assign dattr    = '{rev: 1'b0, ul: 1'b0, bold: 1'b0, bg: dbg_q, fg: dfg_q};
  assign q_pop_o  = take;

  function automatic pos_t goto_xy(input logic signed [9:0] x, input logic signed [9:0] y,
                                   input logic [7:0] cols, input logic [6:0] rows,
                                   input logic org, input logic [ROW_W-1:0] top,
                                   input logic [ROW_W-1:0] bot);
    pos_t r;
    if (x < 0)                           r.col = '0;
    else if (x >= $signed(10'(cols)))   r.col = COL_W'(cols - 8'd1);
    else                                 r.col = x[COL_W-1:0];
    if (y < 0)                           r.row = '0;
    else if (y >= $signed(10'(rows)))   r.row = ROW_W'(rows - 7'd1);
    else                                 r.row = y[ROW_W-1:0];
    if (org) begin
      if (r.row < top)      r.row = top;
      else if (r.row > bot) r.row = bot;
    end
    return r;
  endfunction

  function automatic attr_t sgr_apply(input attr_t a, input logic [7:0] p,
                                      input attr_t dflt);
    attr_t r;
    r = a;
    if (p == SGR_NORM)                          r = dflt;
    else if (p == SGR_BOLD || p == SGR_FAINT)   r.bold = 1'b1;
    else if (p == SGR_UL)                       r.ul = 1'b1;
    else if (p == SGR_REV)                      r.rev = 1'b1;
    else if (p == SGR_NOBOLD)                   r.bold = 1'b0;
    else if (p == SGR_NOUL)                     r.ul = 1'b0;
    else if (p == SGR_NOREV)                    r.rev = 1'b0;
    else if (p == SGR_FG_UL) begin
      r.fg = 3'd7;
      r.ul = 1'b1;
    end else if (p == SGR_FG_DEF) begin
      r.fg = dflt.fg;
      r.ul = 1'b0;
    end else if (p inside {[SGR_FG0:SGR_FG7]}) r.fg = 3'(p - SGR_FG0);
    else if (p inside {[SGR_BG0:SGR_BG7]})     r.bg = 3'(p - SGR_BG0);
    return r;
  endfunction

  always_comb begin : p_exec
    logic [7:0]       c;
    logic             do_print, do_feed, sq, seq_done, fin, eow, wr, last;
    logic             wreq, wsgr, won;
    logic [CNT_W-1:0] cnt_e, cnt_f;
    logic [7:0]       acc_e, par0, par1, p1, p2, p1m, p2m, p1r, p2r, pv;
    logic             priv_e;
    pstate_e          st_e;
    logic [11:0]      prod;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r0, lf_row;
    act_e             act;
    pos_t             g;

    ps_d = ps_q;   priv_d = priv_q; cnt_d = cnt_q; acc_d = acc_q; par_d = par_q;
    col_d = col_q; row_d = row_q;   scol_d = scol_q; srow_d = srow_q;
    wrap_d = wrap_q; attr_d = attr_q; sattr_d = sattr_q;
    top_d = top_q; bot_d = bot_q; org_d = org_q; awm_d = awm_q; lnm_d = lnm_q;
    wsgr_d = wsgr_q; won_d = won_q; weow_d = weow_q; idx_d = idx_q;
    ov_d = ov_q && !out_o.ready;
    res_d = res_q;
    take = 1'b0; start_walk = 1'b0; walk_done = 1'b0;
    c = q_item_i.byte_in;
    do_print = 1'b0; do_feed = 1'b0; sq = 1'b0; seq_done = 1'b0;
    fin = 1'b0; eow = 1'b0; wr = 1'b0; last = 1'b0;
    wreq = 1'b0; wsgr = 1'b0; won = 1'b0;
    cnt_e = '0; cnt_f = '0; acc_e = '0; par0 = '0; par1 = '0;
    p1 = '0; p2 = '0; p1m = '0; p2m = '0; p1r = '0; p2r = '0; pv = '0;
    priv_e = 1'b0; st_e = ps_q; prod = '0;
    c0 = col_q; r0 = row_q; act = ACT_NONE; g = '{col: col_q, row: row_q};
    lf_row = (7'(row_q) + 7'd1 < rows_e) ? ROW_W'(row_q + 6'd1) : row_q;

    if (ex_q == EX_RUN) begin
      if (q_valid_i && out_free) begin
        take = 1'b1;
        fin  = 1'b1;
        eow  = q_item_i.eow;
        case (q_item_i.cls)
          CL_PRINT, CL_DEL: begin
            if (ps_q == PS_NORMAL)          do_print = 1'b1;
            else if (q_item_i.cls == CL_PRINT) do_feed = 1'b1;
          end
          CL_LOWCTL: do_feed = (ps_q != PS_NORMAL);
          CL_NUL:    ;
          CL_BEL:    act = ACT_BELL;
          CL_BS: begin
            if (col_q != '0) begin
              col_d  = COL_W'(col_q - 7'd1);
              wrap_d = 1'b0;
            end
          end
          CL_LF: begin
            row_d  = lf_row;
            wrap_d = 1'b0;
            if (lnm_q) col_d = '0;
          end
          CL_CR: begin
            col_d  = '0;
            wrap_d = 1'b0;
          end
          CL_ABORT: ps_d = PS_NORMAL;
          CL_ESC:   ps_d = PS_ESC;
          CL_CSI:   ps_d = PS_SQUARE;
          default:  ;
        endcase

        // printable byte or DEL: pending wrap first, then write and advance
        if (do_print) begin
          if (wrap_q) begin
            c0 = '0;
            r0 = lf_row;
          end
          wr     = 1'b1;
          act    = ACT_WRITE;
          row_d  = r0;
          if (8'(c0) + 8'd1 >= cols_e) begin
            col_d  = c0;
            wrap_d = awm_q;
          end else begin
            col_d  = COL_W'(c0 + 7'd1);
            wrap_d = 1'b0;
          end
        end

        if (do_feed) begin
          case (ps_q)
            PS_ESC: begin
              ps_d = PS_NORMAL;
              case (c)
                CH_LBRK:         ps_d = PS_SQUARE;
                CH_RBRK, CH_PCT: ps_d = PS_PARK;
                CH_NEL: begin
                  col_d  = '0;
                  row_d  = lf_row;
                  wrap_d = 1'b0;
                end
                CH_IND: begin
                  row_d  = lf_row;
                  wrap_d = 1'b0;
                end
                CH_SAVE: begin
                  scol_d  = col_q;
                  srow_d  = row_q;
                  sattr_d = attr_q;
                end
                CH_REST: begin
                  col_d  = scol_q;
                  row_d  = srow_q;
                  attr_d = sattr_q;
                end
                CH_RIS: begin
                  col_d = '0; row_d = '0; wrap_d = 1'b0;
                  attr_d = dattr; sattr_d = dattr;
                  top_d = '0; bot_d = ROW_W'(rows_e - 7'd1);
                  lnm_d = 1'b1; awm_d = 1'b1; org_d = 1'b0;
                  act = ACT_CLEAR;
                end
                default: ;
              endcase
            end
            PS_SQUARE, PS_GETPARS, PS_INPARS: begin
              sq     = (ps_q == PS_SQUARE);
              cnt_e  = sq ? '0 : cnt_q;
              acc_e  = sq ? 8'd0 : acc_q;
              priv_e = sq ? 1'b0 : priv_q;
              st_e   = sq ? PS_GETPARS : ps_q;
              par0   = sq ? 8'd0 : par_q[0];
              par1   = sq ? 8'd0 : par_q[1];
              // sequence opener clears parameters, then may consume the byte
              if (sq) begin
                par_d  = '{default: '0};
                priv_d = 1'b0;
                cnt_d  = '0;
                acc_d  = '0;
                ps_d   = PS_GETPARS;
                if (c == CH_LBRK) begin
                  ps_d     = PS_PARK;
                  seq_done = 1'b1;
                end else if (c == CH_SS2 || c == CH_SS3) begin
                  seq_done = 1'b1;
                end else if (c == CH_QMARK) begin
                  priv_d   = 1'b1;
                  seq_done = 1'b1;
                end
              end
              if (!seq_done) begin
                if (c == CH_SEMI && cnt_e < CNT_W'(MAX_PARAMS)) begin
                  par_d[cnt_e[IDX_W-1:0]] = acc_e;
                  acc_d = '0;
                  cnt_d = CNT_W'(cnt_e + 1'b1);
                  ps_d  = PS_GETPARS;
                end else if (c >= CH_D0 && c <= CH_D9) begin
                  // surplus digits past the last slot are dropped
                  if (cnt_e < CNT_W'(MAX_PARAMS)) begin
                    prod  = 12'(acc_e) * 12'd10 + 12'(c - CH_D0);
                    acc_d = (prod > 12'd255) ? 8'd255 : prod[7:0];
                    ps_d  = PS_INPARS;
                  end
                end else begin
                  cnt_f = cnt_e;
                  if (st_e == PS_INPARS && cnt_e < CNT_W'(MAX_PARAMS)) begin
                    par_d[cnt_e[IDX_W-1:0]] = acc_e;
                    cnt_f = CNT_W'(cnt_e + 1'b1);
                  end
                  cnt_d = cnt_f;
                  acc_d = '0;
                  ps_d  = PS_NORMAL;
                  p1    = (cnt_e == '0) ? acc_e : par0;
                  p2    = (cnt_e == CNT_W'(1)) ? acc_e : par1;
                  if (priv_e) begin
                    if (c == CH_SM) begin
                      wreq = 1'b1;
                      won  = 1'b1;
                    end else if (c == CH_RM) begin
                      wreq = 1'b1;
                    end
                  end else begin
                    p1m = (p1 == 8'd0 && (c == CH_CUU || c == CH_CUD || c == CH_CUF ||
                           c == CH_CUB || c == CH_CUP)) ? 8'd1 : p1;
                    case (c)
                      CH_CUU: g = goto_xy($signed(10'(col_q)),
                                          $signed(10'(row_q)) - $signed(10'(p1m)),
                                          cols_e, rows_e, org_q, top_q, bot_q);
                      CH_CUD: g = goto_xy($signed(10'(col_q)),
                                          $signed(10'(row_q)) + $signed(10'(p1m)),
                                          cols_e, rows_e, org_q, top_q, bot_q);
                      CH_CUF: g = goto_xy($signed(10'(col_q)) + $signed(10'(p1m)),
                                          $signed(10'(row_q)),
                                          cols_e, rows_e, org_q, top_q, bot_q);
                      CH_CUB: g = goto_xy($signed(10'(col_q)) - $signed(10'(p1m)),
                                          $signed(10'(row_q)),
                                          cols_e, rows_e, org_q, top_q, bot_q);
                      CH_CUP: begin
                        p2m = (p2 == 8'd0) ? 8'd1 : p2;
                        g = goto_xy($signed(10'(p2m)) - 10'sd1,
                                    $signed(10'(p1m)) - 10'sd1 +
                                    (org_q ? $signed(10'(top_q)) : 10'sd0),
                                    cols_e, rows_e, org_q, top_q, bot_q);
                      end
                      CH_SGR: begin
                        wreq = 1'b1;
                        wsgr = 1'b1;
                      end
                      CH_SM: begin
                        wreq = 1'b1;
                        won  = 1'b1;
                      end
                      CH_RM: wreq = 1'b1;
                      CH_STBM: begin
                        p1r = (p1 == 8'd0) ? 8'd1 : p1;
                        p2r = (p2 == 8'd0) ? 8'(rows_e) : p2;
                        if (p1r < p2r && p2r <= 8'(rows_e)) begin
                          top_d = ROW_W'(p1r - 8'd1);
                          bot_d = ROW_W'(p2r - 8'd1);
                          g.col = '0;
                          g.row = org_q ? ROW_W'(p1r - 8'd1) : '0;
                        end
                      end
                      default: ;
                    endcase
                    col_d = g.col;
                    row_d = g.row;
                  end
                  // SGR and modes walk the stored list, one entry a cycle; the last waits for out_o
                  if (wreq && cnt_f != '0) begin
                    start_walk = 1'b1;
                    fin        = 1'b0;
                    wsgr_d     = wsgr;
                    won_d      = won;
                    weow_d     = q_item_i.eow;
                    idx_d      = '0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
    end else begin
      pv   = par_q[idx_q];
      last = (CNT_W'(idx_q) + CNT_W'(1) == cnt_q);
      if (!last || out_free) begin
        if (wsgr_q) begin
          attr_d = sgr_apply(attr_q, pv, dattr);
        end else if (priv_q) begin
          if (pv == DEC_OM) begin
            org_d = won_q;
            col_d = '0;
            row_d = won_q ? top_q : '0;
          end else if (pv == DEC_AWM) begin
            awm_d = won_q;
          end
        end else if (pv == MODE_LNM) begin
          lnm_d = won_q;
        end
        idx_d = IDX_W'(idx_q + 1'b1);
        if (last) begin
          walk_done = 1'b1;
          fin       = 1'b1;
          eow       = weow_q;
        end
      end
    end

    if (fin) begin
      ov_d           = 1'b1;
      res_d.action   = act;
      res_d.glyph    = wr ? c : 8'd0;
      res_d.cell_col = wr ? c0 : '0;
      res_d.cell_row = wr ? r0 : '0;
      res_d.attr     = wr ? attr_q : '0;
      res_d.cur_col  = col_d;
      res_d.cur_row  = row_d;
      res_d.show     = eow;
    end
  end

  always_comb begin : p_ex_next
    ex_d = ex_q;
    case (ex_q)
      EX_RUN:  if (start_walk) ex_d = EX_WALK;
      EX_WALK: if (walk_done)  ex_d = EX_RUN;
      default: ex_d = EX_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RST_ROWS;
      cols_q <= RST_COLS;
      dfg_q  <= RST_FG;
      dbg_q  <= RST_BG;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS: rows_q <= cfg_data_i[6:0];
        CFG_COLS: cols_q <= cfg_data_i;
        CFG_FG:   dfg_q  <= cfg_data_i[2:0];
        CFG_BG:   dbg_q  <= cfg_data_i[2:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= PS_NORMAL; priv_q <= 1'b0; cnt_q <= '0; acc_q <= '0;
      par_q <= '{default: '0};
      col_q <= '0; row_q <= '0; scol_q <= '0; srow_q <= '0; wrap_q <= 1'b0;
      attr_q  <= '{rev: 1'b0, ul: 1'b0, bold: 1'b0, bg: RST_BG, fg: RST_FG};
      sattr_q <= '{rev: 1'b0, ul: 1'b0, bold: 1'b0, bg: RST_BG, fg: RST_FG};
      top_q <= '0; bot_q <= RST_BOT; org_q <= 1'b0; awm_q <= 1'b1; lnm_q <= 1'b1;
      ex_q <= EX_RUN; wsgr_q <= 1'b0; won_q <= 1'b0; weow_q <= 1'b0; idx_q <= '0;
      ov_q <= 1'b0;
    end else begin
      ps_q <= ps_d; priv_q <= priv_d; cnt_q <= cnt_d; acc_q <= acc_d;
      par_q <= par_d;
      col_q <= col_d; row_q <= row_d; scol_q <= scol_d; srow_q <= srow_d;
      wrap_q <= wrap_d; attr_q <= attr_d; sattr_q <= sattr_d;
      top_q <= top_d; bot_q <= bot_d; org_q <= org_d; awm_q <= awm_d; lnm_q <= lnm_d;
      ex_q <= ex_d; wsgr_q <= wsgr_d; won_q <= won_d; weow_q <= weow_d; idx_q <= idx_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid          = ov_q;
  assign out_o.action_code    = res_q.action;
  assign out_o.glyph          = res_q.glyph;
  assign out_o.cell_col       = res_q.cell_col;
  assign out_o.cell_row       = res_q.cell_row;
  assign out_o.cell_fg        = res_q.attr.fg;
  assign out_o.cell_bg        = res_q.attr.bg;
  assign out_o.cell_bold      = res_q.attr.bold;
  assign out_o.cell_underline = res_q.attr.ul;
  assign out_o.cell_reverse   = res_q.attr.rev;
  assign out_o.cursor_col_out = res_q.cur_col;
  assign out_o.cursor_row_out = res_q.cur_row;
  assign out_o.show_cursor    = res_q.show;

endmodule
